// File: rtl/mfsgd_pkg.sv
package mfsgd_pkg;

  localparam int UserBits        = 10;
  localparam int ItemBits        = 10;
  localparam int FactorBits      = 6;
  localparam int MaxFactors      = 64;
  localparam int FacAddrBits     = UserBits + FactorBits;
  localparam int ItemFacAddrBits = ItemBits + FactorBits;
  localparam int UserFacDepth    = 1 << FacAddrBits;
  localparam int ItemFacDepth    = 1 << ItemFacAddrBits;
  localparam int UserDepth       = 1 << UserBits;
  localparam int ItemDepth       = 1 << ItemBits;

  localparam logic [1:0] KindLoad    = 2'd0;
  localparam logic [1:0] KindTrain   = 2'd1;
  localparam logic [1:0] KindPredict = 2'd2;

  localparam logic [1:0] CfgMean   = 2'd0;
  localparam logic [1:0] CfgGain   = 2'd1;
  localparam logic [1:0] CfgReg    = 2'd2;
  localparam logic [1:0] CfgFactor = 2'd3;

  localparam logic ResErr  = 1'b0;
  localparam logic ResPred = 1'b1;

  // Upper clamp of a prediction: 1.0 in Q3.12.
  localparam logic signed [15:0] PredMax = 16'sd4096;

  typedef struct packed {
    logic [1:0]          kind;
    logic [UserBits-1:0] user_row;
    logic [ItemBits-1:0] item_row;
    logic                load_side;
    logic [6:0]          load_slot;
    logic signed [15:0]  load_value;
    logic [14:0]         rating;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] result_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT_RD, ST_DOT_ACC, ST_PRED, ST_BU_MUL, ST_BU_WR,
    ST_BI_MUL, ST_BI_WR, ST_F_RD, ST_F_P, ST_F_PW, ST_F_QL, ST_F_QW, ST_OUT
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
    if (x > 48'sd32767) return 16'sd32767;
    if (x < -48'sd32768) return -16'sd32768;
    return x[15:0];
  endfunction

  function automatic logic signed [47:0] rnd_sh(input logic signed [47:0] x,
                                                input int s);
    logic signed [47:0] y;
    y = x + (48'sd1 <<< (s - 1));
    return y >>> s;
  endfunction

endpackage

// File: rtl/mfsgd_ram.sv
module mfsgd_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/mf_sgd_update_engine_unit.sv
// Channel | Ports                                      | One beat carries
// --------+--------------------------------------------+--------------------------
// in      | in_valid, in_stall, in_data                | a load, train or predict
// out     | out_valid, out_stall, out_data             | an error or a prediction
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
// A load beat is written in its accept cycle, so loads can follow back to back.
// After its accept a predict beat holds the input off through the dot product over
// the K factors, where K is the factor count; a train beat also through the bias
// updates and then the read-modify-write update of each factor in turn.
// Reset clears only control state and the configuration registers; tables are
// undefined until loaded. A finished result waits in the output register while
// new beats are taken; a stalled output holds back the next result and the input.
module mf_sgd_update_engine_unit
  import mfsgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic signed [15:0] mean_r;
  logic [15:0]        gain_r, regw_r;
  logic [6:0]         kcfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      gain_r <= 16'd655;
      regw_r <= '0;
      kcfg_r <= 7'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgMean:   mean_r <= cfg_data;
        CfgGain:   gain_r <= cfg_data;
        CfgReg:    regw_r <= cfg_data;
        CfgFactor: kcfg_r <= cfg_data[6:0];
        default:   ;
      endcase
    end
  end

  // Effective factor count, saturated at the table row width.
  logic [6:0] keff;
  assign keff = (kcfg_r > 7'(MaxFactors)) ? 7'(MaxFactors) : kcfg_r;

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic [6:0] f_r, f_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [15:0] err_r, err_nxt;
  logic signed [17:0] lam_r, lam_nxt;
  logic signed [19:0] x_r, x_nxt;
  logic signed [15:0] newp_r, newp_nxt;
  logic signed [15:0] bu_r, bi_r;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Memory ports.
  logic uf_we, if_we, ub_we, ib_we;
  logic [FacAddrBits-1:0] uf_wa, uf_ra;
  logic [ItemFacAddrBits-1:0] if_wa, if_ra;
  logic [15:0] uf_wd, if_wd, ub_wd, ib_wd, uf_rd, if_rd, ub_rd, ib_rd;
  logic [UserBits-1:0] ub_wa, ub_ra;
  logic [ItemBits-1:0] ib_wa, ib_ra;

  mfsgd_ram #(.Width(16), .Depth(UserFacDepth)) u_uf (
    .clk, .we(uf_we), .waddr(uf_wa), .wdata(uf_wd), .raddr(uf_ra), .rdata(uf_rd));
  mfsgd_ram #(.Width(16), .Depth(ItemFacDepth)) u_if (
    .clk, .we(if_we), .waddr(if_wa), .wdata(if_wd), .raddr(if_ra), .rdata(if_rd));
  mfsgd_ram #(.Width(16), .Depth(UserDepth)) u_ub (
    .clk, .we(ub_we), .waddr(ub_wa), .wdata(ub_wd), .raddr(ub_ra), .rdata(ub_rd));
  mfsgd_ram #(.Width(16), .Depth(ItemDepth)) u_ib (
    .clk, .we(ib_we), .waddr(ib_wa), .wdata(ib_wd), .raddr(ib_ra), .rdata(ib_rd));

  // Factor reads follow the current row and factor. The bias reads look at the
  // incoming beat while idle, so both biases are ready in the first dot cycle.
  assign uf_ra = {item_r.user_row, f_r[FactorBits-1:0]};
  assign if_ra = {item_r.item_row, f_r[FactorBits-1:0]};
  assign ub_ra = (state_r == ST_IDLE) ? in_data.user_row : item_r.user_row;
  assign ib_ra = (state_r == ST_IDLE) ? in_data.item_row : item_r.item_row;

  logic accept;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Operands of the shared update datapath. upd(w, x) is split over two
  // steps: the first registers rnd(lambda*w, 16) and, for a factor, the
  // rounded product of the error and the partner factor; the second forms
  // the new word.
  logic signed [15:0] lam_src, ex_src, upd_w;
  logic signed [19:0] upd_x;

  always_comb begin
    lam_src = bu_r;
    ex_src  = if_rd;
    upd_w   = bu_r;
    upd_x   = 20'(err_r);
    case (state_r)
      ST_BI_MUL, ST_BI_WR: begin
        lam_src = bi_r;
        upd_w   = bi_r;
      end
      ST_F_P, ST_F_PW: begin
        lam_src = uf_rd;
        upd_w   = uf_rd;
        upd_x   = x_r;
      end
      ST_F_QL, ST_F_QW: begin
        // The item factor update uses the user factor just written.
        lam_src = if_rd;
        ex_src  = newp_r;
        upd_w   = if_rd;
        upd_x   = x_r;
      end
      default: ;
    endcase
  end

  logic signed [32:0] lam_prod;
  logic signed [31:0] ex_prod, dot_prod;
  logic signed [20:0] t_sum;
  logic signed [37:0] g_prod;
  logic signed [47:0] lam_full, ex_full, g_full, upd_res;
  logic signed [15:0] upd_out;
  logic signed [47:0] pred_w, pe;
  logic signed [15:0] pclamp;

  always_comb begin
    lam_prod = $signed({1'b0, regw_r}) * lam_src;
    lam_full = rnd_sh(48'(lam_prod), 16);
    // |e*w| <= 2^30, so the product rounded by 12 fits in 20 signed bits.
    ex_prod  = err_r * ex_src;
    ex_full  = rnd_sh(48'(ex_prod), 12);
    t_sum    = 21'(upd_x) + 21'(lam_r);
    g_prod   = $signed({1'b0, gain_r}) * t_sum;
    g_full   = rnd_sh(48'(g_prod), 16);
    upd_res  = 48'(upd_w) - g_full;
    upd_out  = sat16(upd_res);
    dot_prod = $signed(uf_rd) * $signed(if_rd);
    pred_w   = 48'(mean_r) + 48'(bu_r) + 48'(bi_r) + rnd_sh(acc_r, 12);
    pe       = pred_w - 48'(signed'({1'b0, item_r.rating}));
    if (pred_w < 48'sd0) pclamp = '0;
    else if (pred_w > 48'(PredMax)) pclamp = PredMax;
    else pclamp = pred_w[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    f_nxt = f_r;
    acc_nxt = acc_r;
    err_nxt = err_r;
    lam_nxt = lam_r;
    x_nxt = x_r;
    newp_nxt = newp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    uf_we = 1'b0; if_we = 1'b0; ub_we = 1'b0; ib_we = 1'b0;
    uf_wa = {in_data.user_row, in_data.load_slot[FactorBits-1:0]};
    if_wa = {in_data.item_row, in_data.load_slot[FactorBits-1:0]};
    ub_wa = in_data.user_row;
    ib_wa = in_data.item_row;
    uf_wd = in_data.load_value; if_wd = in_data.load_value;
    ub_wd = in_data.load_value; ib_wd = in_data.load_value;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          f_nxt = '0;
          acc_nxt = '0;
          case (in_data.kind)
            KindLoad: begin
              if (in_data.load_slot < 7'(MaxFactors)) begin
                uf_we = !in_data.load_side;
                if_we = in_data.load_side;
              end else if (in_data.load_slot == 7'(MaxFactors)) begin
                ub_we = !in_data.load_side;
                ib_we = in_data.load_side;
              end
            end
            KindTrain, KindPredict: state_nxt = ST_DOT_RD;
            default: ;
          endcase
        end
      end
      ST_DOT_RD: begin
        // Factor f is being read; its data arrives in the next cycle.
        state_nxt = (f_r < keff) ? ST_DOT_ACC : ST_PRED;
      end
      ST_DOT_ACC: begin
        acc_nxt = acc_r + 48'(dot_prod);
        f_nxt = f_r + 7'd1;
        state_nxt = ST_DOT_RD;
      end
      ST_PRED: begin
        f_nxt = '0;
        if (item_r.kind == KindPredict) begin
          state_nxt = ST_OUT;
        end else begin
          err_nxt = sat16(pe);
          state_nxt = ST_BU_MUL;
        end
      end
      ST_BU_MUL: begin
        lam_nxt = lam_full[17:0];
        state_nxt = ST_BU_WR;
      end
      ST_BU_WR: begin
        ub_we = 1'b1;
        ub_wa = item_r.user_row;
        ub_wd = upd_out;
        state_nxt = ST_BI_MUL;
      end
      ST_BI_MUL: begin
        lam_nxt = lam_full[17:0];
        state_nxt = ST_BI_WR;
      end
      ST_BI_WR: begin
        ib_we = 1'b1;
        ib_wa = item_r.item_row;
        ib_wd = upd_out;
        state_nxt = ST_F_RD;
      end
      ST_F_RD: begin
        // Read p[f] and q[f]; both stay on the read ports through the step.
        state_nxt = (f_r < keff) ? ST_F_P : ST_OUT;
      end
      ST_F_P: begin
        lam_nxt = lam_full[17:0];
        x_nxt = ex_full[19:0];
        state_nxt = ST_F_PW;
      end
      ST_F_PW: begin
        uf_we = 1'b1;
        uf_wa = uf_ra;
        uf_wd = upd_out;
        newp_nxt = upd_out;
        state_nxt = ST_F_QL;
      end
      ST_F_QL: begin
        lam_nxt = lam_full[17:0];
        x_nxt = ex_full[19:0];
        state_nxt = ST_F_QW;
      end
      ST_F_QW: begin
        if_we = 1'b1;
        if_wa = if_ra;
        if_wd = upd_out;
        f_nxt = f_r + 7'd1;
        state_nxt = ST_F_RD;
      end
      ST_OUT: begin
        // Wait here while an older result is still held by the receiver.
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          if (item_r.kind == KindPredict) begin
            out_nxt.result_kind = ResPred;
            out_nxt.result_value = pclamp;
          end else begin
            out_nxt.result_kind = ResErr;
            out_nxt.result_value = err_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    f_r    <= f_nxt;
    acc_r  <= acc_nxt;
    err_r  <= err_nxt;
    lam_r  <= lam_nxt;
    x_r    <= x_nxt;
    newp_r <= newp_nxt;
    out_r  <= out_nxt;
    if (state_r == ST_DOT_RD) begin
      bu_r <= ub_rd;
      bi_r <= ib_rd;
    end
  end

endmodule
